/* rtl/ptw_pkg.sv */
package ptw_pkg;

  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 52;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned LIMIT_W    = 49;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned ENTRY_SHIFT = 3;
  localparam int unsigned FRAME_W    = PA_W - PAGE_SHIFT;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_USER    = 2;

  localparam logic [PA_W-1:0]    ROOT_BASE_RST = '0;
  localparam logic [LIMIT_W-1:0] VA_LIMIT_RST  = LIMIT_W'(1) << 47;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_RESPONSE  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_NOT_USER    = 2'd2,
    ST_RANGE       = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_BASE = 2'd0,
    REG_VA_LIMIT  = 2'd1
  } reg_idx_e;

  typedef struct packed {
    cmd_e               command;
    logic [VA_W-1:0]    virt_addr;
    logic [ENTRY_W-1:0] mem_data;
  } cmd_t;

  typedef struct packed {
    kind_e           kind;
    logic [PA_W-1:0] read_addr;
    logic [PA_W-1:0] phys_frame;
    status_e         status;
  } res_t;

  typedef struct packed {
    logic [FRAME_W-1:0] root_frame;
    logic [LIMIT_W-1:0] va_limit;
  } cfg_t;

endpackage

/* rtl/ptw_if.sv */
interface ptw_cmd_if import ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [VA_W-1:0]    virt_addr;
  logic [ENTRY_W-1:0] mem_data;

  modport source (output valid, command, virt_addr, mem_data, input ready);
  modport sink   (input valid, command, virt_addr, mem_data, output ready);
endinterface

interface ptw_res_if import ptw_pkg::*; ();
  logic            valid;
  logic            ready;
  kind_e           kind;
  logic [PA_W-1:0] read_addr;
  logic [PA_W-1:0] phys_frame;
  status_e         status;

  modport source (output valid, kind, read_addr, phys_frame, status, input ready);
  modport sink   (input valid, kind, read_addr, phys_frame, status, output ready);
endinterface

interface ptw_cfg_if import ptw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ptw_cfg.sv */
module ptw_cfg import ptw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptw_cfg_if.sink      cfg_i,
  output cfg_t         cfg_o
);

  logic [FRAME_W-1:0] root_frame_q;
  logic [LIMIT_W-1:0] va_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= ROOT_BASE_RST[PA_W-1:PAGE_SHIFT];
      va_limit_q   <= VA_LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROOT_BASE: root_frame_q <= cfg_i.data[PA_W-1:PAGE_SHIFT];
        REG_VA_LIMIT:  va_limit_q   <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.root_frame = root_frame_q;
  assign cfg_o.va_limit   = va_limit_q;

endmodule

/* rtl/ptw_core.sv */
module ptw_core import ptw_pkg::*; #(
  parameter int unsigned LEVELS = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ptw_cmd_if.sink cmd_i,
  input  cfg_t    cfg_i,
  input  logic    res_ready_i,
  output logic    res_valid_o,
  output res_t    res_o
);

  localparam int unsigned LVL_W  = $clog2(LEVELS + 1);
  localparam int unsigned SPAN_W = PAGE_SHIFT + INDEX_BITS * LEVELS;
  localparam int unsigned VAX_W  = (SPAN_W > VA_W) ? SPAN_W : VA_W;

  logic             in_vld_q;
  cmd_t             in_q;
  logic             fire;
  logic             busy_q, busy_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [VA_W-1:0]  va_q, va_d;

  logic [LVL_W-1:0]      walk_lvl;
  logic [VAX_W-1:0]      va_ext;
  logic [INDEX_BITS-1:0] idx;
  logic [FRAME_W-1:0]    base_frame;
  logic [PA_W-1:0]       entry_addr;

  assign fire        = in_vld_q && res_ready_i;
  assign cmd_i.ready = !in_vld_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_q.command   <= cmd_i.command;
      in_q.virt_addr <= cmd_i.virt_addr;
      in_q.mem_data  <= cmd_i.mem_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lvl_q  <= '0;
      va_q   <= '0;
    end else if (fire) begin
      busy_q <= busy_d;
      lvl_q  <= lvl_d;
      va_q   <= va_d;
    end
  end

  // level and address whose slice indexes the next entry
  always_comb begin
    if (in_q.command == CMD_TRANSLATE) begin
      walk_lvl   = LVL_W'(LEVELS);
      va_ext     = VAX_W'(in_q.virt_addr);
      base_frame = cfg_i.root_frame;
    end else begin
      walk_lvl   = lvl_q - LVL_W'(1);
      va_ext     = VAX_W'(va_q);
      base_frame = in_q.mem_data[PA_W-1:PAGE_SHIFT];
    end
    idx = '0;
    for (int unsigned l = 1; l <= LEVELS; l++) begin
      if (walk_lvl == LVL_W'(l)) begin
        idx = va_ext[PAGE_SHIFT + INDEX_BITS * (l - 1) +: INDEX_BITS];
      end
    end
    entry_addr = {base_frame, idx, {ENTRY_SHIFT{1'b0}}};
  end

  always_comb begin
    busy_d      = busy_q;
    lvl_d       = lvl_q;
    va_d        = va_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_READ, read_addr: '0, phys_frame: '0, status: ST_OK};
    unique case (in_q.command)
      CMD_TRANSLATE: begin
        if (!busy_q) begin
          res_valid_o = 1'b1;
          if ({1'b0, in_q.virt_addr} >= cfg_i.va_limit) begin
            res_o.kind   = KIND_DONE;
            res_o.status = ST_RANGE;
          end else begin
            busy_d          = 1'b1;
            lvl_d           = LVL_W'(LEVELS);
            va_d            = in_q.virt_addr;
            res_o.read_addr = entry_addr;
          end
        end
      end
      CMD_RESPONSE: begin
        if (busy_q) begin
          res_valid_o = 1'b1;
          if (!in_q.mem_data[BIT_PRESENT]) begin
            busy_d       = 1'b0;
            lvl_d        = '0;
            res_o.kind   = KIND_DONE;
            res_o.status = ST_NOT_PRESENT;
          end else if (lvl_q > LVL_W'(1)) begin
            lvl_d           = walk_lvl;
            res_o.read_addr = entry_addr;
          end else begin
            busy_d     = 1'b0;
            lvl_d      = '0;
            res_o.kind = KIND_DONE;
            if (!in_q.mem_data[BIT_USER]) begin
              res_o.status = ST_NOT_USER;
            end else begin
              res_o.phys_frame = {in_q.mem_data[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            end
          end
        end
      end
      default: ;
    endcase
    res_valid_o = res_valid_o && in_vld_q;
  end

endmodule

/* rtl/ptw_out.sv */
module ptw_out import ptw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  res_t      res_i,
  output logic      ready_o,
  ptw_res_if.source res_o
);

  logic vld_q;
  res_t res_q;

  assign ready_o = !vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid      = vld_q;
  assign res_o.kind       = res_q.kind;
  assign res_o.read_addr  = res_q.read_addr;
  assign res_o.phys_frame = res_q.phys_frame;
  assign res_o.status     = res_q.status;

endmodule

/* rtl/four_level_page_table_walker.sv */
// Page-table walker. Translate and read-response items enter on cmd_i; each
// produces at most one item on res_o: a read request for the next table entry
// or a finished translation with its status. One item is taken per cycle
// while the sink keeps taking results; an item is held in the input register
// once accepted, and its result is loaded from there into the result register,
// which drives res_o. cmd_i.ready drops only while the result register holds
// an item the sink has not taken. Items that arrive at the wrong moment
// (translate while walking, response while idle) are dropped without a
// result. Configuration writes on cfg_i are always ready and must be made
// while no walk is in flight.
module four_level_page_table_walker import ptw_pkg::*; #(
  parameter int unsigned LEVELS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptw_cfg_if.sink   cfg_i,
  ptw_cmd_if.sink   cmd_i,
  ptw_res_if.source res_o
);

  cfg_t cfg;
  logic core_valid;
  res_t core_res;
  logic out_ready;

  ptw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ptw_core #(
    .LEVELS (LEVELS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg),
    .res_ready_i (out_ready),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  ptw_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .res_i   (core_res),
    .ready_o (out_ready),
    .res_o   (res_o)
  );

endmodule
